FILE: sv/life_grid_generation_step_defines.svh
// assertion macros for the life grid block
// no dependencies; included by files that carry assertions
`ifndef LIFE_GRID_GENERATION_STEP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LGS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lgs_pkg.sv
// shared types and constants for the life grid block
// no dependencies
package lgs_pkg;

  localparam int ROW_W = 5;
  localparam int COL_W = 6;
  localparam int GEN_W = 32;

  typedef enum logic [1:0] {
    MODE_TOGGLE = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_STEP   = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_TGL_RD,
    ST_TGL_WR,
    ST_STEP,
    ST_FIN_RD,
    ST_FIN
  } state_t;

endpackage

FILE: sv/lgs_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/life_grid_generation_step.sv
// game of life grid (rule b3/s23) with generation counter, one grid row per ram word
// depends on lgs_pkg, lgs_ram and life_grid_generation_step_defines.svh
//
// usage
//   a command word (in_mode, in_row, in_col) is taken at a rising edge with start high
//   and busy low. modes: toggle a cell, clear the grid, step one generation, read a cell.
//   every command returns one result word (out_cell_alive, out_generation) marked by a
//   one-cycle out_valid strobe; the receiver must take it, there is no back pressure.
// busy drops in the same cycle that out_valid rises, so the next command may be
//   issued while the result is on the ports.
// throughput is set by the single grid ram: a step streams every row through the read
//   port once, one row per cycle, and writes each new interior row back one row behind,
//   so the length of a step does not depend on COLS.
// reset
//   rst_n low clears the counter; after release the block runs a clearing sweep over
//   every row of the grid ram with busy high, and then goes idle. no result word is
//   produced by this sweep.
// an address outside the grid returns a dead cell and toggle leaves the grid alone.
module life_grid_generation_step #(
  parameter int ROWS = 32,
  parameter int COLS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_mode,
  input  logic [lgs_pkg::ROW_W-1:0] in_row,
  input  logic [lgs_pkg::COL_W-1:0] in_col,
  output logic                      out_valid,
  output logic                      out_cell_alive,
  output logic [lgs_pkg::GEN_W-1:0] out_generation
);

  `include "life_grid_generation_step_defines.svh"

  // address and index widths
  localparam int AW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLS);
  localparam int RW   = (AW > lgs_pkg::ROW_W) ? AW : lgs_pkg::ROW_W;
  localparam int CXW  = (CW > lgs_pkg::COL_W) ? CW : lgs_pkg::COL_W;
  localparam int CNTW = $clog2(ROWS + 1);

  lgs_pkg::state_t state_r, state_nxt;
  lgs_pkg::mode_t  mode_r, mode_nxt;

  logic [lgs_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [lgs_pkg::COL_W-1:0] col_r, col_nxt;
  logic [lgs_pkg::GEN_W-1:0] gen_r, gen_nxt;
  logic [CNTW-1:0]           cnt_r, cnt_nxt;
  logic                      cmd_r, cmd_nxt;     // a command is behind the current sweep
  logic [COLS-1:0]           up_r, up_nxt;       // old row above the one being rebuilt
  logic [COLS-1:0]           mid_r, mid_nxt;     // old row being rebuilt
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_cell_r, out_cell_nxt;
  logic [lgs_pkg::GEN_W-1:0] out_gen_r, out_gen_nxt;

  // grid ram port signals
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [COLS-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [COLS-1:0] ram_rdata;

  logic            accept;
  logic            addr_ok;
  logic [RW-1:0]   row_wide;
  logic [CXW-1:0]  col_wide;
  logic [AW-1:0]   row_idx;
  logic [CW-1:0]   col_idx;
  logic [CNTW-1:0] cnt_m2;
  logic [COLS-1:0] life_row;

  lgs_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != lgs_pkg::ST_IDLE);
  assign accept = start && !busy;

  // addressed cell, widened or cut down to the grid index widths
  assign row_wide = RW'(row_r);
  assign col_wide = CXW'(col_r);
  assign row_idx  = row_wide[AW-1:0];
  assign col_idx  = col_wide[CW-1:0];
  assign addr_ok  = (32'(row_r) < ROWS) && (32'(col_r) < COLS);
  assign cnt_m2   = cnt_r - CNTW'(2);

  // next row from three old rows: up_r above, mid_r itself, ram_rdata below
  always_comb begin
    logic [3:0] n;
    n        = '0;
    life_row = mid_r;
    for (int c = 1; c < COLS - 1; c++) begin
      n = 4'(up_r[c-1]) + 4'(up_r[c]) + 4'(up_r[c+1])
        + 4'(mid_r[c-1]) + 4'(mid_r[c+1])
        + 4'(ram_rdata[c-1]) + 4'(ram_rdata[c]) + 4'(ram_rdata[c+1]);
      life_row[c] = (n == 4'd3) || (mid_r[c] && (n == 4'd2));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgs_pkg::ST_CLR;
      cnt_r       <= '0;
      cmd_r       <= 1'b0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmd_r       <= cmd_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    out_cell_r <= out_cell_nxt;
    out_gen_r  <= out_gen_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    gen_nxt       = gen_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    out_cell_nxt  = out_cell_r;
    out_gen_nxt   = out_gen_r;
    ram_we        = 1'b0;
    ram_waddr     = row_idx;
    ram_wdata     = ram_rdata;
    ram_raddr     = row_idx;

    case (state_r)
      lgs_pkg::ST_IDLE: begin
        if (accept) begin
          mode_nxt = lgs_pkg::mode_t'(in_mode);
          row_nxt  = in_row;
          col_nxt  = in_col;
          cnt_nxt  = '0;
          cmd_nxt  = 1'b1;
          case (lgs_pkg::mode_t'(in_mode))
            lgs_pkg::MODE_TOGGLE: state_nxt = lgs_pkg::ST_TGL_RD;
            lgs_pkg::MODE_CLEAR: begin
              gen_nxt   = '0;
              state_nxt = lgs_pkg::ST_CLR;
            end
            lgs_pkg::MODE_STEP: begin
              gen_nxt   = gen_r + 1'b1;   // wraps at 32 bits
              state_nxt = lgs_pkg::ST_STEP;
            end
            default: state_nxt = lgs_pkg::ST_FIN_RD;
          endcase
        end
      end

      // zero sweep, one row per cycle, after reset and on clear
      lgs_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = '0;
        if (cnt_r == CNTW'(ROWS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = cmd_r ? lgs_pkg::ST_FIN_RD : lgs_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // read-modify-write of the addressed row
      lgs_pkg::ST_TGL_RD: state_nxt = lgs_pkg::ST_TGL_WR;

      lgs_pkg::ST_TGL_WR: begin
        ram_we    = addr_ok;
        ram_wdata = ram_rdata ^ (COLS'(1) << col_idx);
        state_nxt = lgs_pkg::ST_FIN_RD;
      end

      // rows stream in one per cycle; at count k the read data is old row k-1,
      // and from k = 3 on, new row k-2 is written back behind the read pointer
      lgs_pkg::ST_STEP: begin
        ram_raddr = cnt_r[AW-1:0];
        if (cnt_r != '0) begin
          up_nxt  = mid_r;
          mid_nxt = ram_rdata;
        end
        if (cnt_r >= CNTW'(3)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m2[AW-1:0];
          ram_wdata = life_row;
        end
        if (cnt_r == CNTW'(ROWS)) begin
          cnt_nxt   = '0;
          state_nxt = lgs_pkg::ST_FIN_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // final read of the addressed row for the result word
      lgs_pkg::ST_FIN_RD: state_nxt = lgs_pkg::ST_FIN;

      lgs_pkg::ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_cell_nxt  = addr_ok && ram_rdata[col_idx];
        out_gen_nxt   = gen_r;
        state_nxt     = lgs_pkg::ST_IDLE;
      end

      default: state_nxt = lgs_pkg::ST_IDLE;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_cell_r;
  assign out_generation = out_gen_r;

  `LGS_ASSERT_NEXT(a_fin_gives_word, clk, rst_n, state_r == lgs_pkg::ST_FIN,
                   out_valid, "final state did not produce a result word")
  `LGS_ASSERT_NOW(a_clear_word_zero, clk, rst_n,
                  out_valid && (mode_r == lgs_pkg::MODE_CLEAR),
                  (out_generation == '0) && !out_cell_alive, "clear result not zero")
  `LGS_ASSERT_NOW(a_no_write_idle, clk, rst_n, state_r == lgs_pkg::ST_IDLE,
                  !ram_we, "grid written while idle")
  `LGS_ASSERT_NEXT(a_gen_holds, clk, rst_n, !accept, $stable(gen_r),
                   "generation moved without a command")
  `LGS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy,
                   "accepted command did not raise busy")

endmodule

FILE: dv/life_grid_generation_step_test.sv
// self-checking testbench for life_grid_generation_step: game of life grid with generation counter
// holds its own grid model and compares every result word against it
// depends on lgs_pkg and the life_grid_generation_step rtl
module life_grid_generation_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 32;
  localparam int COLS = 64;
  localparam int RANDOM_WORDS = 250;
  localparam int REPORT_LIMIT = 10;

  // one expected result word, with the command that caused it for messages
  typedef struct {
    lgs_pkg::mode_t           mode;
    logic [lgs_pkg::ROW_W-1:0] row;
    logic [lgs_pkg::COL_W-1:0] col;
    logic                     alive;
    logic [lgs_pkg::GEN_W-1:0] generation;
  } cell_report_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_mode;
  logic [lgs_pkg::ROW_W-1:0] in_row;
  logic [lgs_pkg::COL_W-1:0] in_col;
  logic                      out_valid;
  logic                      out_cell_alive;
  logic [lgs_pkg::GEN_W-1:0] out_generation;

  life_grid_generation_step #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_row        (in_row),
    .in_col        (in_col),
    .out_valid     (out_valid),
    .out_cell_alive(out_cell_alive),
    .out_generation(out_generation)
  );

  // model of the grid, one packed row per grid row, bit index is the column
  logic [COLS-1:0]           grid_model [ROWS];
  logic [lgs_pkg::GEN_W-1:0] generation_model;

  // result words still owed by the block, oldest first
  cell_report_t pending_reports[$];

  int mismatch_count;
  int reports_checked;
  int words_sent;
  int mode_sent [4];
  int burst_left;

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous limit, well beyond the longest step and the longest sender gap
  initial begin
    #10_000_000;
    $display("timeout: %0d words sent, %0d result words still owed",
             words_sent, pending_reports.size());
    $display("** life_grid_generation_step: FAILED **");
    $finish;
  end

  // next generation under b3/s23, border rows and columns are held
  function automatic void advance_grid_model();
    logic [COLS-1:0] prior [ROWS];
    int live;
    prior = grid_model;
    for (int r = 1; r < ROWS - 1; r++) begin
      for (int c = 1; c < COLS - 1; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) live += prior[r + dr][c + dc];
          end
        end
        if (prior[r][c]) grid_model[r][c] = (live == 2 || live == 3);
        else grid_model[r][c] = (live == 3);
      end
    end
    // the 32-bit wrap is out of reach in a run of this length
    generation_model = generation_model + 1'b1;
  endfunction

  // apply one command to the model and return the word the block owes for it
  function automatic cell_report_t apply_command(lgs_pkg::mode_t mode,
                                                 logic [lgs_pkg::ROW_W-1:0] row,
                                                 logic [lgs_pkg::COL_W-1:0] col);
    cell_report_t report;
    logic on_grid;
    on_grid = (int'(row) < ROWS) && (int'(col) < COLS);
    case (mode)
      lgs_pkg::MODE_TOGGLE: begin
        if (on_grid) grid_model[row][col] = ~grid_model[row][col];
      end
      lgs_pkg::MODE_CLEAR: begin
        foreach (grid_model[r]) grid_model[r] = '0;
        generation_model = '0;
      end
      lgs_pkg::MODE_STEP: begin
        advance_grid_model();
      end
      default: begin
      end
    endcase
    report.mode       = mode;
    report.row        = row;
    report.col        = col;
    report.alive      = on_grid ? grid_model[row][col] : 1'b0;
    report.generation = generation_model;
    return report;
  endfunction

  function automatic int clamp(int value, int lo, int hi);
    return (value < lo) ? lo : (value > hi) ? hi : value;
  endfunction

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  // send one command word; the sender works in bursts with random gaps between them,
  // so start rises at every phase of the block's work, busy or not
  task automatic send_word(lgs_pkg::mode_t mode, int row, int col);
    int gap;
    cell_report_t report;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start   = 1'b1;
    in_mode = mode;
    in_row  = row[lgs_pkg::ROW_W-1:0];
    in_col  = col[lgs_pkg::COL_W-1:0];
    // accepted at the first rising edge that sees busy low
    do @(posedge clk); while (busy);
    report = apply_command(mode, row[lgs_pkg::ROW_W-1:0], col[lgs_pkg::COL_W-1:0]);
    pending_reports.push_back(report);
    words_sent++;
    mode_sent[mode]++;
  endtask

  // hold the sender off until every owed result word has come back
  task automatic wait_for_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // result checker: every strobe must match the oldest owed word
  always @(posedge clk) begin
    cell_report_t want;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        note_mismatch($sformatf("result word with none owed: alive %0b generation %0d",
                                out_cell_alive, out_generation));
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_cell_alive !== want.alive)
          note_mismatch($sformatf("%s (%0d,%0d) cell_alive expected %0b got %0b",
                                  want.mode.name(), want.row, want.col, want.alive,
                                  out_cell_alive));
        if (out_generation !== want.generation)
          note_mismatch($sformatf("%s (%0d,%0d) generation expected %0d got %0d",
                                  want.mode.name(), want.row, want.col, want.generation,
                                  out_generation));
      end
    end
  end

  // fresh grid must read dead everywhere with a zero counter
  task automatic test_reset_state();
    send_word(lgs_pkg::MODE_READ, 0, 0);
    send_word(lgs_pkg::MODE_READ, ROWS - 1, COLS - 1);
  endtask

  // toggles at all four corners, one flipped back, covering every address bit both ways
  task automatic test_toggle_extremes();
    send_word(lgs_pkg::MODE_TOGGLE, 0, 0);
    send_word(lgs_pkg::MODE_TOGGLE, ROWS - 1, COLS - 1);
    send_word(lgs_pkg::MODE_TOGGLE, 0, COLS - 1);
    send_word(lgs_pkg::MODE_TOGGLE, ROWS - 1, 0);
    send_word(lgs_pkg::MODE_TOGGLE, ROWS - 1, COLS - 1);
    send_word(lgs_pkg::MODE_READ, ROWS - 1, COLS - 1);
  endtask

  // live border cells have too few neighbors but must survive a step
  task automatic test_border_hold();
    send_word(lgs_pkg::MODE_STEP, 0, 0);
    send_word(lgs_pkg::MODE_READ, ROWS - 1, 0);
    send_word(lgs_pkg::MODE_READ, 0, COLS - 1);
  endtask

  // blinker covers birth and lonely death, a plus sign covers death by crowding
  task automatic test_life_rules();
    send_word(lgs_pkg::MODE_TOGGLE, 10, 10);
    send_word(lgs_pkg::MODE_TOGGLE, 10, 11);
    send_word(lgs_pkg::MODE_TOGGLE, 10, 12);
    send_word(lgs_pkg::MODE_STEP, 9, 11);
    send_word(lgs_pkg::MODE_READ, 10, 10);
    send_word(lgs_pkg::MODE_TOGGLE, 20, 30);
    send_word(lgs_pkg::MODE_TOGGLE, 19, 30);
    send_word(lgs_pkg::MODE_TOGGLE, 21, 30);
    send_word(lgs_pkg::MODE_TOGGLE, 20, 29);
    send_word(lgs_pkg::MODE_TOGGLE, 20, 31);
    send_word(lgs_pkg::MODE_STEP, 20, 30);
  endtask

  // clear kills the grid and zeroes the counter
  task automatic test_clear();
    send_word(lgs_pkg::MODE_CLEAR, 9, 11);
    send_word(lgs_pkg::MODE_READ, 0, 0);
  endtask

  // random soups: seed a small patch, run it a few generations and probe around it,
  // mixed with noise words anywhere on the grid
  task automatic test_random_soups();
    int first_word;
    int soups;
    int r0;
    int c0;
    int seeds;
    int steps;
    int probes;
    first_word = words_sent;
    soups = 0;
    while (words_sent - first_word < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 7) begin
        soups++;
        // now and then let the block drain completely before the next soup
        if (soups % 6 == 0) wait_for_results();
        // most soups sit inside, some straddle the border
        if ($urandom_range(0, 4) == 0) begin
          r0 = $urandom_range(0, ROWS - 1);
          c0 = $urandom_range(0, COLS - 1);
        end else begin
          r0 = $urandom_range(3, ROWS - 4);
          c0 = $urandom_range(4, COLS - 5);
        end
        seeds = $urandom_range(3, 16);
        repeat (seeds)
          send_word(lgs_pkg::MODE_TOGGLE,
                    clamp(r0 + $urandom_range(0, 4) - 2, 0, ROWS - 1),
                    clamp(c0 + $urandom_range(0, 6) - 3, 0, COLS - 1));
        steps = $urandom_range(1, 5);
        repeat (steps) begin
          send_word(lgs_pkg::MODE_STEP, clamp(r0 + $urandom_range(0, 6) - 3, 0, ROWS - 1),
                    clamp(c0 + $urandom_range(0, 6) - 3, 0, COLS - 1));
          probes = $urandom_range(0, 3);
          repeat (probes)
            send_word(lgs_pkg::MODE_READ,
                      clamp(r0 + $urandom_range(0, 8) - 4, 0, ROWS - 1),
                      clamp(c0 + $urandom_range(0, 8) - 4, 0, COLS - 1));
        end
        if ($urandom_range(0, 3) == 0)
          send_word(lgs_pkg::MODE_CLEAR, $urandom_range(0, ROWS - 1),
                    $urandom_range(0, COLS - 1));
      end else begin
        send_word(lgs_pkg::mode_t'($urandom_range(0, 3)), $urandom_range(0, ROWS - 1),
                  $urandom_range(0, COLS - 1));
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_mode  = lgs_pkg::MODE_READ;
    in_row   = '0;
    in_col   = '0;
    mismatch_count  = 0;
    reports_checked = 0;
    words_sent      = 0;
    burst_left      = 0;
    mode_sent       = '{default: 0};
    foreach (grid_model[r]) grid_model[r] = '0;
    generation_model = '0;

    // synchronous reset, then the block sweeps the grid with busy high
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_toggle_extremes();
    test_border_hold();
    test_life_rules();
    test_clear();
    test_random_soups();

    // drain, then give a late or extra word time to show up
    wait_for_results();
    repeat (60) @(posedge clk);

    if (pending_reports.size() != 0) begin
      mismatch_count += pending_reports.size();
      $display("%0d result words never arrived", pending_reports.size());
    end
    $display("sent %0d command words: %0d toggle, %0d clear, %0d step, %0d read",
             words_sent, mode_sent[lgs_pkg::MODE_TOGGLE], mode_sent[lgs_pkg::MODE_CLEAR],
             mode_sent[lgs_pkg::MODE_STEP], mode_sent[lgs_pkg::MODE_READ]);
    $display("checked %0d result words, reached generation %0d, %0d mismatches",
             reports_checked, generation_model, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** life_grid_generation_step: PASSED **");
    end else begin
      $display("** life_grid_generation_step: FAILED **");
    end
    $finish;
  end

endmodule
